### hdl/isfmc_pkg.sv
// Shared types, register indexes, codes and reset values of the shock, fall and motion classifier.
package isfmc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SHOCK_LEVEL     = 3'd0,
    REG_TILT_TAN_SQ     = 3'd1,
    REG_FALL_CONFIRM_MS = 3'd2,
    REG_BUMP_RECOVER_MS = 3'd3,
    REG_SMOOTHING_GAIN  = 3'd4,
    REG_MOTION_LEVEL    = 3'd5
  } cfg_reg_t;

  // Register values after reset.
  localparam logic [15:0] SHOCK_LEVEL_RST     = 16'd29491;
  localparam logic [15:0] TILT_TAN_SQ_RST     = 16'd768;
  localparam logic [15:0] FALL_CONFIRM_MS_RST = 16'd1500;
  localparam logic [15:0] BUMP_RECOVER_MS_RST = 16'd500;
  localparam logic [16:0] SMOOTHING_GAIN_RST  = 17'd9830;
  localparam logic [14:0] MOTION_LEVEL_RST    = 15'd819;

  // Unity gain in Q16.
  localparam logic [16:0] GAIN_ONE = 17'd65536;

  localparam logic [1:0] EVENT_NONE = 2'd0;
  localparam logic [1:0] EVENT_BUMP = 2'd1;
  localparam logic [1:0] EVENT_FALL = 2'd2;

  localparam logic [1:0] MOTION_STEADY = 2'd0;
  localparam logic [1:0] MOTION_ACCEL  = 2'd1;
  localparam logic [1:0] MOTION_DECEL  = 2'd2;

  // Multiplier passes per sample and the width of the step counter.
  localparam int NUM_STEPS = 8;
  localparam int STEP_W    = 4;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;
  } sample_word_t;

  typedef struct packed {
    logic [1:0]         impact_event;
    logic               shock_tracking;
    logic               large_tilt;
    logic [1:0]         motion_state;
    logic signed [15:0] filtered_forward;
  } result_word_t;

endpackage

### hdl/imu_shock_fall_motion_classifier_top.sv
// Top level of the shock, fall and motion classifier with its shared multiplier sequencer.
//
//  Channel   Signals                              Word / fields
//  --------  -----------------------------------  ---------------------------------------
//  sample    sample_valid, sample_ready, sample   accel_x, accel_y, accel_z, time_ms
//  result    result_valid, result_ready, result   impact_event, shock_tracking,
//                                                 large_tilt, motion_state, filtered_forward
//  config    cfg_write, cfg_index, cfg_data       six registers, write only
//
// Each sample runs eight passes through the one 18 x 34 bit signed
// multiplier, then folds the last product into the filter, and then
// classifies and loads the result; the sequencer then returns to idle.
// A new sample is taken once the sequencer is back in idle, even while the
// previous result still waits on result_ready; a stalled result holds the
// sequencer in its final state. Reset is synchronous and restores all
// configuration registers to their defaults, clears tracking, the shock
// time and the filter.
module imu_shock_fall_motion_classifier_top
  import isfmc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  sample_word_t           sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_word_t           result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS);

  state_t state;
  logic [STEP_W-1:0] step;

  // Configuration registers.
  logic [15:0] shock_level;
  logic [15:0] tilt_tan_sq_q8;
  logic [15:0] fall_confirm_ms;
  logic [15:0] bump_recover_ms;
  logic [16:0] smoothing_gain_q16;
  logic [14:0] motion_level;

  // Persistent classifier state.
  logic               tracking_flag;
  logic [31:0]        shock_start_time;
  logic signed [31:0] smoothed_forward;

  // The captured sample.
  logic signed [15:0] x_r, y_r, z_r;
  logic [31:0]        now_r;

  // Intermediate products, each captured the cycle after its pass.
  logic signed [51:0] prod;
  logic [30:0]        xx, yy, zz;
  logic [31:0]        yz;
  logic [31:0]        lvl_sq;
  logic [46:0]        t_zz;
  logic [47:0]        t_yz;
  logic signed [33:0] ax;

  logic signed [17:0] opa;
  logic signed [33:0] opb;
  logic [16:0]        gain;
  logic [16:0]        gain_rest;
  logic signed [51:0] filt_num;
  logic [32:0]        mag_sq;
  logic               roll_big, pitch_big, tilt_big;
  logic [31:0]        elapsed;
  logic signed [31:0] motion_lim;
  logic [1:0]         motion_next;
  logic [1:0]         event_next;
  logic               tracking_next;
  logic               shock_hit;
  logic               result_load;

  assign sample_ready = (state == ST_IDLE);

  // The final cycle loads the result register once it is empty or being emptied.
  assign result_load = (state == ST_FIN) && (!result_valid || result_ready);

  // Gains above one follow the input.
  assign gain      = (smoothing_gain_q16 > GAIN_ONE) ? GAIN_ONE : smoothing_gain_q16;
  assign gain_rest = GAIN_ONE - gain;

  // Operand selection for the shared multiplier, one product per step.
  always_comb begin
    case (step[2:0])
      3'd0: begin
        opa = {{2{x_r[15]}}, x_r};
        opb = {{18{x_r[15]}}, x_r};
      end
      3'd1: begin
        opa = {{2{y_r[15]}}, y_r};
        opb = {{18{y_r[15]}}, y_r};
      end
      3'd2: begin
        opa = {{2{z_r[15]}}, z_r};
        opb = {{18{z_r[15]}}, z_r};
      end
      3'd3: begin
        opa = {2'b00, shock_level};
        opb = {18'd0, shock_level};
      end
      3'd4: begin
        opa = {2'b00, tilt_tan_sq_q8};
        opb = {3'd0, zz};
      end
      3'd5: begin
        opa = {2'b00, tilt_tan_sq_q8};
        opb = {2'b00, yz};
      end
      3'd6: begin
        opa = {1'b0, gain};
        opb = {{18{x_r[15]}}, x_r};
      end
      default: begin
        opa = {1'b0, gain_rest};
        opb = {{2{smoothed_forward[31]}}, smoothed_forward};
      end
    endcase
  end

  // Filter numerator: (a*x*65536 + (1-a)*state) scaled by 65536, plus one half, rounded by the floor shift.
  assign filt_num = {{2{ax[33]}}, ax, 16'd0} + prod + 52'sd32768;

  // Squared-tangent tilt tests; a negative z always counts as rolled over.
  assign roll_big  = z_r[15] || ({9'd0, yy, 8'd0} > {1'b0, t_zz});
  assign pitch_big = {9'd0, xx, 8'd0} > t_yz;
  assign tilt_big  = roll_big || pitch_big;

  assign mag_sq  = {2'b00, xx} + {2'b00, yy} + {2'b00, zz};
  assign elapsed = now_r - shock_start_time;

  always_comb begin
    shock_hit     = 1'b0;
    event_next    = EVENT_NONE;
    tracking_next = tracking_flag;
    if (!tracking_flag) begin
      if (mag_sq > {1'b0, lvl_sq}) begin
        shock_hit     = 1'b1;
        tracking_next = 1'b1;
      end
    end else if (tilt_big && (elapsed > {16'd0, fall_confirm_ms})) begin
      event_next    = EVENT_FALL;
      tracking_next = 1'b0;
    end else if (!tilt_big && (elapsed > {16'd0, bump_recover_ms})) begin
      event_next    = EVENT_BUMP;
      tracking_next = 1'b0;
    end
  end

  assign motion_lim = {1'b0, motion_level, 16'd0};

  always_comb begin
    if (smoothed_forward > motion_lim) begin
      motion_next = MOTION_ACCEL;
    end else if (smoothed_forward < -motion_lim) begin
      motion_next = MOTION_DECEL;
    end else begin
      motion_next = MOTION_STEADY;
    end
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      shock_level        <= SHOCK_LEVEL_RST;
      tilt_tan_sq_q8     <= TILT_TAN_SQ_RST;
      fall_confirm_ms    <= FALL_CONFIRM_MS_RST;
      bump_recover_ms    <= BUMP_RECOVER_MS_RST;
      smoothing_gain_q16 <= SMOOTHING_GAIN_RST;
      motion_level       <= MOTION_LEVEL_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SHOCK_LEVEL:     shock_level        <= cfg_data[15:0];
        REG_TILT_TAN_SQ:     tilt_tan_sq_q8     <= cfg_data[15:0];
        REG_FALL_CONFIRM_MS: fall_confirm_ms    <= cfg_data[15:0];
        REG_BUMP_RECOVER_MS: bump_recover_ms    <= cfg_data[15:0];
        REG_SMOOTHING_GAIN:  smoothing_gain_q16 <= cfg_data;
        REG_MOTION_LEVEL:    motion_level       <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      x_r   <= sample.accel_x;
      y_r   <= sample.accel_y;
      z_r   <= sample.accel_z;
      now_r <= sample.time_ms;
    end
    if (state == ST_RUN) begin
      prod <= opa * opb;
      case (step)
        4'd1: xx <= prod[30:0];
        4'd2: yy <= prod[30:0];
        4'd3: begin
          zz <= prod[30:0];
          yz <= {1'b0, yy} + {1'b0, prod[30:0]};
        end
        4'd4: lvl_sq <= prod[31:0];
        4'd5: t_zz   <= prod[46:0];
        4'd6: t_yz   <= prod[47:0];
        4'd7: ax     <= prod[33:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer, classifier state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      step             <= '0;
      tracking_flag    <= 1'b0;
      shock_start_time <= '0;
      smoothed_forward <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (sample_valid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step == LAST_STEP) begin
            smoothed_forward <= filt_num[47:16];
            state            <= ST_FIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_FIN: begin
          if (result_load) begin
            tracking_flag <= tracking_next;
            if (shock_hit) begin
              shock_start_time <= now_r;
            end
            result.impact_event     <= event_next;
            result.shock_tracking   <= tracking_next;
            result.large_tilt       <= tilt_big;
            result.motion_state     <= motion_next;
            result.filtered_forward <= smoothed_forward[31:16];
            state                   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A confirmed fall or bump always ends the tracking.
  a_event_ends_tracking: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.impact_event != EVENT_NONE) |-> !result.shock_tracking)
    else $error("impact reported while tracking stays set");

  // An accepted sample keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample accepted twice in a row");

  // The step counter never runs past LAST_STEP, the filter fold step after the last multiplier pass.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= LAST_STEP))
    else $error("step counter out of range");
`endif

endmodule
